// ===== hdl/tcdc_pkg.sv =====
// Package for the TAC code-density calibration unit: sizes, status codes,
// register indexes and the request/result structs. No dependencies.
package tcdc_pkg;

  localparam int NUM_BINS        = 4096;
  localparam int BIN_W           = $clog2(NUM_BINS);
  localparam int BIN_IDX_W       = BIN_W + 1;
  localparam int MAX_CHANNELS    = 512;
  localparam int CH_W            = $clog2(MAX_CHANNELS);
  localparam int HIST_AW         = CH_W + BIN_W;
  localparam int EXTRA_STRIDE    = 20;
  localparam int FIRST_BIN_FLOOR = 1000;
  localparam int CNT_W           = 32;
  localparam int SUM_W           = CNT_W + BIN_W;
  localparam int TIME_W          = 25;
  localparam int TIME_STEP_FS    = 70000;
  localparam logic [TIME_W-1:0] TIME_SCALE_FS = 25'd24998190;

  localparam int CFG_W  = 32;
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] CFG_NUM_PMTS  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_NUM_EXTRA = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_MIN_STATS = 2'd2;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_IGNORED  = 3'd1;
  localparam logic [2:0] ST_ILLEGAL  = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_NO_CAL   = 3'd4;

  typedef struct packed {
    logic        mode;
    logic [9:0]  event_hits;
    logic [1:0]  cal_kind;
    logic        is_extra;
    logic [7:0]  bar;
    logic [1:0]  side;
    logic [3:0]  group_index;
    logic [4:0]  converter_address;
    logic [11:0] tac_data;
    logic [8:0]  query_channel;
  } tcdc_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [12:0]       bin_low;
    logic [12:0]       bin_high;
    logic [TIME_W-1:0] time_fs;
    logic              last;
  } tcdc_out_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] part;
    logic [SUM_W-1:0] total;
  } scale_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] q;
  } scale_rsp_t;

endpackage

// ===== hdl/tac_code_density_calibration_unit.sv =====
// Top level of the TAC code-density calibration unit: sequencer, histogram
// and entry-count memories, time scaler. Depends on tcdc_pkg, tcdc_ram,
// tcdc_scale.
//
//  channel | ports                         | moves
//  --------+-------------------------------+------------------------------
//  input   | in_valid/in_ready/in_data     | one hit or range request
//  output  | out_valid/out_ready/out_data  | one result per request
//  config  | cfg_we/cfg_index/cfg_wdata    | register write, no wait
//
// A legal hit goes through accept, memory read, write-back and result load; an
// ignored or illegal hit skips the write-back. A range request sweeps the
// channel histogram through the single read port: a full sweep for the total,
// then a prefix sum up to the first range end, then time scaling and a decision
// for every range end tried, the prefix sum taking one more bin for every bin
// the range widens by. A final or empty range adds a channel clear.
// After reset the histogram is cleared; in_ready stays low meanwhile.
// A result waits in the output register; the next request is taken meanwhile,
// but its result holds the sequencer, with in_ready low, until the register frees.
module tac_code_density_calibration_unit import tcdc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcdc_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tcdc_out_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam logic [3:0] S_CLR_ALL = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_HIT     = 4'd2;
  localparam logic [3:0] S_HIT_WB  = 4'd3;
  localparam logic [3:0] S_RD      = 4'd4;
  localparam logic [3:0] S_RD_ENT  = 4'd5;
  localparam logic [3:0] S_SUM     = 4'd6;
  localparam logic [3:0] S_CUM     = 4'd7;
  localparam logic [3:0] S_DIV     = 4'd8;
  localparam logic [3:0] S_DEC     = 4'd9;
  localparam logic [3:0] S_CLEAR   = 4'd10;
  localparam logic [3:0] S_EMIT    = 4'd11;

  // configuration
  logic [8:0]       num_pmts_r;
  logic [8:0]       num_extra_r;
  logic [CNT_W-1:0] min_stats_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_pmts_r  <= '0;
      num_extra_r <= '0;
      min_stats_r <= 32'd100000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_PMTS:  num_pmts_r  <= cfg_wdata[8:0];
        CFG_NUM_EXTRA: num_extra_r <= cfg_wdata[8:0];
        CFG_MIN_STATS: min_stats_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [3:0]           state_r, state_nxt;
  tcdc_in_t             req_r, req_nxt;
  logic [CH_W-1:0]      ch_r, ch_nxt;
  logic [HIST_AW-1:0]   cnt_r, cnt_nxt;
  tcdc_out_t            res_r, res_nxt;
  logic [CH_W-1:0]      read_channel_r, read_channel_nxt;
  logic [BIN_IDX_W-1:0] next_bin_r, next_bin_nxt;
  logic [BIN_IDX_W-1:0] range_end_r, range_end_nxt;
  logic [TIME_W-1:0]    prev_time_r, prev_time_nxt;
  logic                 read_active_r, read_active_nxt;
  logic                 starting_r, starting_nxt;
  logic [BIN_IDX_W-1:0] sw_idx_r, sw_idx_nxt;
  logic [BIN_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [SUM_W-1:0]     total_r, total_nxt;
  logic [SUM_W-1:0]     cum_r, cum_nxt;
  logic [BIN_IDX_W-1:0] lo_r, lo_nxt;
  logic [BIN_IDX_W-1:0] hi_r, hi_nxt;
  logic                 lo_found_r, lo_found_nxt;
  logic [BIN_IDX_W-1:0] end_r, end_nxt;
  logic                 tvalid_r, tvalid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tcdc_out_t            out_data_r;
  logic                 out_load;

  // memory ports
  logic               hist_we;
  logic [HIST_AW-1:0] hist_waddr, hist_raddr;
  logic [CNT_W-1:0]   hist_wdata, hist_rdata;
  logic               ent_we;
  logic [CH_W-1:0]    ent_waddr, ent_raddr;
  logic [CNT_W-1:0]   ent_wdata, ent_rdata;

  scale_req_t scale_req;
  scale_rsp_t scale_rsp;

  tcdc_ram #(.W(CNT_W), .AW(HIST_AW)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  tcdc_ram #(.W(CNT_W), .AW(CH_W)) u_entries (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  tcdc_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (scale_req),
    .rsp   (scale_rsp)
  );

  // hit classification from the held request
  logic [7:0]         half;
  logic               hit_ignore;
  logic signed [11:0] pmt_off;
  logic signed [11:0] pmt_ch;
  logic [11:0]        extra_ch;
  logic signed [11:0] hit_ch_s;
  logic               hit_illegal;
  logic [CH_W-1:0]    hit_ch;
  logic               hit_bin_ok;
  logic               qch_ok;

  assign half = num_pmts_r[8:1];
  assign hit_ignore = (req_r.event_hits > {2'b00, half}) ||
                      !((req_r.cal_kind == 2'd1) || (req_r.cal_kind == 2'd2)) ||
                      (req_r.bar > half);

  always_comb begin
    unique case (req_r.side)
      2'd0:    pmt_off = -$signed({4'b0000, half});
      2'd1:    pmt_off = '0;
      2'd2:    pmt_off = $signed({4'b0000, half});
      default: pmt_off = $signed({3'b000, half, 1'b0});
    endcase
  end

  assign pmt_ch   = pmt_off + $signed({4'b0000, req_r.bar}) - 12'sd1;
  assign extra_ch = {3'b000, num_pmts_r} +
                    12'(req_r.group_index) * 12'(EXTRA_STRIDE) +
                    12'(req_r.converter_address);
  assign hit_ch_s = req_r.is_extra ? $signed(extra_ch) : pmt_ch;
  assign hit_illegal = (hit_ch_s < 12'sd0) ||
                       ($unsigned(hit_ch_s) >= 12'({1'b0, num_pmts_r} +
                                                  {1'b0, num_extra_r})) ||
                       ($unsigned(hit_ch_s) >= 12'(MAX_CHANNELS));
  assign hit_ch     = hit_ch_s[CH_W-1:0];
  assign hit_bin_ok = 13'(req_r.tac_data) < 13'(NUM_BINS);
  assign qch_ok = ({1'b0, req_r.query_channel} <
                   ({1'b0, num_pmts_r} + {1'b0, num_extra_r})) &&
                  (11'(req_r.query_channel) < 11'(MAX_CHANNELS));

  // sweep helpers
  logic                 issue_sum, issue_cum;
  logic [TIME_W-1:0]    t_sel;
  logic                 grow;
  logic [TIME_W-1:0]    prev_sel;
  logic                 is_last;

  assign issue_sum = sw_idx_r < BIN_IDX_W'(NUM_BINS);
  assign issue_cum = (sw_idx_r <= end_r) && (sw_idx_r < BIN_IDX_W'(NUM_BINS));
  assign t_sel     = tvalid_r ? scale_rsp.q : '0;
  assign is_last   = end_r > range_end_r;
  assign grow      = !is_last && tvalid_r &&
                     ({1'b0, t_sel} < ({1'b0, prev_time_r} + (TIME_W+1)'(TIME_STEP_FS)));
  assign prev_sel  = tvalid_r ? t_sel : prev_time_r;

  always_comb begin
    state_nxt        = state_r;
    req_nxt          = req_r;
    ch_nxt           = ch_r;
    cnt_nxt          = cnt_r;
    res_nxt          = res_r;
    read_channel_nxt = read_channel_r;
    next_bin_nxt     = next_bin_r;
    range_end_nxt    = range_end_r;
    prev_time_nxt    = prev_time_r;
    read_active_nxt  = read_active_r;
    starting_nxt     = starting_r;
    sw_idx_nxt       = sw_idx_r;
    rd_idx_nxt       = rd_idx_r;
    rd_vld_nxt       = 1'b0;
    total_nxt        = total_r;
    cum_nxt          = cum_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    lo_found_nxt     = lo_found_r;
    end_nxt          = end_r;
    tvalid_nxt       = tvalid_r;
    out_load         = 1'b0;
    in_ready         = 1'b0;
    hist_we          = 1'b0;
    hist_waddr       = {ch_r, req_r.tac_data};
    hist_wdata       = '0;
    hist_raddr       = {ch_r, sw_idx_r[BIN_W-1:0]};
    ent_we           = 1'b0;
    ent_waddr        = ch_r;
    ent_wdata        = '0;
    ent_raddr        = ch_r;
    scale_req.start  = 1'b0;
    scale_req.part   = cum_r;
    scale_req.total  = total_r;

    unique case (state_r)
      S_CLR_ALL: begin
        // clear the whole histogram; entry counts ride along on the low bits
        hist_we    = 1'b1;
        hist_waddr = cnt_r;
        ent_we     = 1'b1;
        ent_waddr  = cnt_r[CH_W-1:0];
        cnt_nxt    = cnt_r + 1'b1;
        if (&cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = in_data.mode ? S_RD : S_HIT;
        end
      end
      S_HIT: begin
        ch_nxt     = hit_ch;
        res_nxt    = '0;
        ent_raddr  = hit_ch;
        hist_raddr = {hit_ch, req_r.tac_data};
        priority if (hit_ignore) begin
          res_nxt.status = ST_IGNORED;
          state_nxt      = S_EMIT;
        end else if (hit_illegal) begin
          res_nxt.status = ST_ILLEGAL;
          state_nxt      = S_EMIT;
        end else begin
          res_nxt.status = ST_ACCEPTED;
          state_nxt      = S_HIT_WB;
        end
      end
      S_HIT_WB: begin
        // saturating increments of entry count and bin
        ent_we     = 1'b1;
        ent_wdata  = (&ent_rdata) ? ent_rdata : ent_rdata + 1'b1;
        hist_we    = hit_bin_ok;
        hist_wdata = (&hist_rdata) ? hist_rdata : hist_rdata + 1'b1;
        state_nxt  = S_EMIT;
      end
      S_RD: begin
        ch_nxt       = req_r.query_channel;
        ent_raddr    = req_r.query_channel;
        res_nxt      = '0;
        sw_idx_nxt   = '0;
        total_nxt    = '0;
        lo_found_nxt = 1'b0;
        hi_nxt       = '0;
        lo_nxt       = '0;
        if (read_active_r && (read_channel_r == req_r.query_channel)) begin
          starting_nxt = 1'b0;
          state_nxt    = S_SUM;
        end else begin
          read_active_nxt = 1'b0;
          if (qch_ok) begin
            state_nxt = S_RD_ENT;
          end else begin
            res_nxt.status = ST_NO_CAL;
            state_nxt      = S_EMIT;
          end
        end
      end
      S_RD_ENT: begin
        if (ent_rdata < min_stats_r) begin
          res_nxt.status = ST_NO_CAL;
          state_nxt      = S_EMIT;
        end else begin
          starting_nxt = 1'b1;
          state_nxt    = S_SUM;
        end
      end
      S_SUM: begin
        // full sweep: total, and on a fresh read the first and last busy bins
        if (issue_sum) begin
          sw_idx_nxt = sw_idx_r + 1'b1;
          rd_idx_nxt = sw_idx_r[BIN_W-1:0];
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          total_nxt = total_r + SUM_W'(hist_rdata);
          if (hist_rdata > 32'd1) begin
            hi_nxt = {1'b0, rd_idx_r} + 1'b1;
            if (!lo_found_r && (rd_idx_r > BIN_W'(FIRST_BIN_FLOOR))) begin
              lo_nxt       = {1'b0, rd_idx_r};
              lo_found_nxt = 1'b1;
            end
          end
        end
        if (!issue_sum && !rd_vld_r) begin
          sw_idx_nxt = '0;
          cum_nxt    = '0;
          if (starting_r) begin
            if (!lo_found_r) begin
              res_nxt.status = ST_NO_CAL;
              cnt_nxt        = '0;
              state_nxt      = S_CLEAR;
            end else begin
              read_channel_nxt = ch_r;
              next_bin_nxt     = lo_r;
              range_end_nxt    = hi_r;
              prev_time_nxt    = '0;
              read_active_nxt  = 1'b1;
              end_nxt          = lo_r + 1'b1;
              state_nxt        = S_CUM;
            end
          end else begin
            end_nxt   = next_bin_r + 1'b1;
            state_nxt = S_CUM;
          end
        end
      end
      S_CUM: begin
        // prefix sum up to the range end, clamped at the top bin
        if (issue_cum) begin
          sw_idx_nxt = sw_idx_r + 1'b1;
          rd_idx_nxt = sw_idx_r[BIN_W-1:0];
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          cum_nxt = cum_r + SUM_W'(hist_rdata);
        end
        if (!issue_cum && !rd_vld_r) begin
          tvalid_nxt = (cum_r != '0) && (total_r != '0);
          if ((cum_r != '0) && (total_r != '0)) begin
            scale_req.start = 1'b1;
            state_nxt       = S_DIV;
          end else begin
            state_nxt = S_DEC;
          end
        end
      end
      S_DIV: begin
        if (scale_rsp.done) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (grow) begin
          end_nxt   = end_r + 1'b1;
          state_nxt = S_CUM;
        end else begin
          prev_time_nxt    = prev_sel;
          res_nxt.status   = ST_RANGE;
          res_nxt.bin_low  = next_bin_r;
          res_nxt.bin_high = end_r - 1'b1;
          res_nxt.time_fs  = prev_sel;
          res_nxt.last     = is_last;
          next_bin_nxt     = end_r;
          if (is_last) begin
            read_active_nxt = 1'b0;
            cnt_nxt         = '0;
            state_nxt       = S_CLEAR;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_CLEAR: begin
        // wipe one channel, one bin a cycle
        hist_we    = 1'b1;
        hist_waddr = {ch_r, cnt_r[BIN_W-1:0]};
        ent_we     = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (&cnt_r[BIN_W-1:0]) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR_ALL;
      cnt_r         <= '0;
      read_active_r <= 1'b0;
      read_channel_r <= '0;
      next_bin_r    <= '0;
      range_end_r   <= '0;
      prev_time_r   <= '0;
      out_valid_r   <= 1'b0;
      rd_vld_r      <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      read_active_r <= read_active_nxt;
      read_channel_r <= read_channel_nxt;
      next_bin_r    <= next_bin_nxt;
      range_end_r   <= range_end_nxt;
      prev_time_r   <= prev_time_nxt;
      out_valid_r   <= out_valid_nxt;
      rd_vld_r      <= rd_vld_nxt;
    end
    req_r      <= req_nxt;
    ch_r       <= ch_nxt;
    res_r      <= res_nxt;
    starting_r <= starting_nxt;
    sw_idx_r   <= sw_idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    total_r    <= total_nxt;
    cum_r      <= cum_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    lo_found_r <= lo_found_nxt;
    end_r      <= end_nxt;
    tvalid_r   <= tvalid_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/tcdc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcdc_ram #(
  parameter int W  = 32,
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tcdc_scale.sv =====
// Iterative time scaler: floor(TIME_SCALE_FS * part / total), one partial
// step per cycle (double, add, reduce per bit). Depends on tcdc_pkg.
module tcdc_scale import tcdc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  scale_req_t req,
  output scale_rsp_t rsp
);

  localparam int R_W = SUM_W + 1;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [4:0]        bit_r, bit_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic [R_W-1:0]    r_r, r_nxt;
  logic [TIME_W-1:0] q_r, q_nxt;
  logic [SUM_W-1:0]  part_r, part_nxt;
  logic [SUM_W-1:0]  total_r, total_nxt;
  logic [R_W-1:0]    r_shift;

  assign r_shift = {r_r[R_W-2:0], 1'b0};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    bit_nxt   = bit_r;
    ph_nxt    = ph_r;
    r_nxt     = r_r;
    q_nxt     = q_r;
    part_nxt  = part_r;
    total_nxt = total_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      bit_nxt   = 5'(TIME_W - 1);
      ph_nxt    = 2'd0;
      r_nxt     = '0;
      q_nxt     = '0;
      part_nxt  = req.part;
      total_nxt = req.total;
    end else if (busy_r) begin
      unique case (ph_r)
        2'd0: begin
          // double remainder and quotient, then reduce once
          if (r_shift >= {1'b0, total_r}) begin
            r_nxt = r_shift - {1'b0, total_r};
            q_nxt = {q_r[TIME_W-2:0], 1'b1};
          end else begin
            r_nxt = r_shift;
            q_nxt = {q_r[TIME_W-2:0], 1'b0};
          end
          ph_nxt = 2'd1;
        end
        2'd1: begin
          if (TIME_SCALE_FS[bit_r]) begin
            r_nxt = r_r + {1'b0, part_r};
          end
          ph_nxt = 2'd2;
        end
        default: begin
          if (r_r >= {1'b0, total_r}) begin
            r_nxt = r_r - {1'b0, total_r};
            q_nxt = q_r + 1'b1;
          end
          ph_nxt = 2'd0;
          if (bit_r == 5'd0) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else begin
            bit_nxt = bit_r - 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bit_r   <= bit_nxt;
    ph_r    <= ph_nxt;
    r_r     <= r_nxt;
    q_r     <= q_nxt;
    part_r  <= part_nxt;
    total_r <= total_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule

// ===== hdl/tcdc_checker.sv =====
// Port-level checker for the calibration unit, bound to the top level.
// Depends on tcdc_pkg.
module tcdc_checker import tcdc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input tcdc_out_t         out_data,
  input logic              cfg_we
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // results other than a range carry zero fields
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_RANGE) |->
      (out_data.bin_low == '0) && (out_data.bin_high == '0) &&
      (out_data.time_fs == '0) && !out_data.last)
    else $error("non-range result with payload");

  // a range never runs backward
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_RANGE) |->
      out_data.bin_low <= out_data.bin_high)
    else $error("range with high below low");

  // register writes must land only while the unit is idle; the unit does not enforce it, this checks it
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> in_ready)
    else $error("configuration written while busy");

endmodule

bind tac_code_density_calibration_unit tcdc_checker u_tcdc_checker (.*);
